// ===== rtl/core/c402_pkg.sv =====
// shared types and constants for the cia402 drive state master
`default_nettype none
package c402_pkg;

    typedef enum logic [1:0] {
        OP_SYNC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_HALT  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_NOT_READY    = 3'd0,
        ST_DISABLED     = 3'd1,
        ST_READY        = 3'd2,
        ST_SWITCHED_ON  = 3'd3,
        ST_ENABLED      = 3'd4,
        ST_QUICKSTOP    = 3'd5,
        ST_FAULT_REACT  = 3'd6,
        ST_FAULT        = 3'd7
    } dev_state_t;

    typedef enum logic [0:0] {
        CFG_TARGET_ENABLE = 1'b0,
        CFG_HOMING_ENABLE = 1'b1
    } cfg_index_t;

    localparam logic [7:0] MODE_PP     = 8'd1;
    localparam logic [7:0] MODE_VL     = 8'd2;
    localparam logic [7:0] MODE_PV     = 8'd3;
    localparam logic [7:0] MODE_HOMING = 8'd6;
    localparam logic [7:0] MODE_IP     = 8'd7;
    localparam logic [6:0] MODE_REQ_HOMING = 7'd6;
    localparam logic [6:0] MODE_REQ_NONE   = 7'd0;

    localparam logic [15:0] SW_MASK      = 16'h006F;
    localparam logic [15:0] HOMING_BITS  = 16'h3400;
    localparam logic [15:0] HOMING_OK    = 16'h1400;
    localparam logic [15:0] CW_MODE_BITS = 16'h0070;
    localparam logic [15:0] CW_MODE0     = 16'h0010;
    localparam logic [15:0] CW_HALT      = 16'h0100;

    localparam logic [7:0] PAT_SHUTDOWN  = 8'h06;
    localparam logic [7:0] PAT_SWITCH_ON = 8'h07;
    localparam logic [7:0] PAT_DISABLE_V = 8'h00;
    localparam logic [7:0] PAT_QUICKSTOP = 8'h02;
    localparam logic [7:0] PAT_ENABLE_OP = 8'h0F;
    localparam logic [7:0] PAT_FAULT_RST = 8'h80;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [15:0]       drive_status;
        logic signed [7:0] mode_display;
        logic              position_changed;
    } in_item_t;

    typedef struct packed {
        logic [15:0] ctrl_word;
        logic [2:0]  device_state;
        logic        unknown_status;
        logic        transition_pending;
        logic [6:0]  mode_request;
        logic        homing_done;
        logic        motor_ready;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        opcode_t    op;
        dev_state_t state;
        logic       unknown;
        logic       homing_ok;
        logic [7:0] mode;
        logic       position_changed;
    } cmd_t;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

endpackage
`default_nettype wire

// ===== rtl/core/cia402_drive_state_master_core.sv =====
// top level of the cia402 drive state master
// usage:
//   in channel (in_valid, in_stall, in_data) carries one word per item: opcode
//   sync, write mode bits, halt or nop, with the drive status word and mode display.
//   out channel (out_valid, out_stall, out_data) returns exactly one result word
//   per input word, in order: control word, device state and status flags.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes target
//   enable (index 0) or homing enable (index 1); cfg_ready is always high.
//   writing homing enable also rearms the homing pending flag.
// timing:
//   a word is classified in the front end, waits in a two-entry queue and is
//   carried out by the back end, which registers the result. the word enters
//   the queue at the accepting edge and the result register when popped.
//   while out_stall is low one word per cycle is sustained, and the back end
//   retires one word per cycle.
// reset: drive state not ready, control word zero, config and flags cleared.
// stall: while out_stall is high the result holds, the queue fills, and
//   in_stall rises once both queue entries are occupied.
`default_nettype none
module cia402_drive_state_master_core
    import c402_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic      cfg_data
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic queue_valid;
    cmd_t queue_head;
    logic pop;

    assign cfg_ready = 1'b1;

    c402_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    c402_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (queue_head)
    );

    c402_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (queue_valid),
        .cmd       (queue_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/core/c402_front.sv =====
// front end: accepts items, decodes the status word and classifies the opcode
`default_nettype none
module c402_front
    import c402_pkg::*;
(
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     queue_full,
    output logic          push,
    output cmd_t          push_cmd
);

    logic [6:0]  sw_masked;
    logic [2:0]  dec_state;
    logic        dec_unknown;

    assign in_stall  = queue_full;
    assign push      = in_valid && !queue_full;
    assign sw_masked = in_data.drive_status[6:0] & SW_MASK[6:0];

    always_comb
    begin
        dec_state   = 3'd0;
        dec_unknown = 1'b0;
        case (sw_masked)
            7'h00, 7'h20: dec_state = ST_NOT_READY;
            7'h40, 7'h60: dec_state = ST_DISABLED;
            7'h21:        dec_state = ST_READY;
            7'h23:        dec_state = ST_SWITCHED_ON;
            7'h27:        dec_state = ST_ENABLED;
            7'h07:        dec_state = ST_QUICKSTOP;
            7'h0F, 7'h2F: dec_state = ST_FAULT_REACT;
            7'h08, 7'h28: dec_state = ST_FAULT;
            default:      dec_unknown = 1'b1;
        endcase
    end

    always_comb
    begin
        push_cmd.op               = opcode_t'(in_data.opcode);
        push_cmd.state            = dev_state_t'(dec_state);
        push_cmd.unknown          = dec_unknown;
        push_cmd.homing_ok        = (in_data.drive_status & HOMING_BITS) == HOMING_OK;
        push_cmd.mode             = in_data.mode_display;
        push_cmd.position_changed = in_data.position_changed;
    end

endmodule
`default_nettype wire

// ===== rtl/core/c402_queue.sv =====
// two-entry command queue between front and back
`default_nettype none
module c402_queue
    import c402_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full      = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/c402_back.sv =====
// back end: drive state, control word update and the result register
`default_nettype none
module c402_back
    import c402_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_write,
    input  wire logic cfg_index,
    input  wire logic cfg_data,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_data
);

    logic       target_enable_reg;
    logic       homing_enable_reg;
    logic [2:0] drive_state_reg;
    logic [2:0] drive_state_next;
    logic [15:0] control_bits_reg;
    logic [15:0] control_bits_next;
    logic       homing_pending_reg;
    logic       homing_pending_next;
    logic       new_target_reg;
    logic       new_target_next;
    logic [7:0] current_mode_reg;
    logic [7:0] current_mode_next;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    logic [2:0] target;
    logic       to_enable;
    logic       load_pat;
    logic [7:0] pat;

    assign pop       = cmd_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign to_enable = target_enable_reg;
    assign target    = target_enable_reg ? ST_ENABLED : ST_DISABLED;

    // next transition pattern from the state after decode
    always_comb
    begin
        load_pat = 1'b0;
        pat      = PAT_DISABLE_V;
        case (drive_state_next)
            ST_FAULT:
            begin
                load_pat = 1'b1;
                pat      = PAT_FAULT_RST;
            end
            ST_NOT_READY, ST_DISABLED:
            begin
                load_pat = to_enable;
                pat      = PAT_SHUTDOWN;
            end
            ST_READY:
            begin
                load_pat = 1'b1;
                pat      = to_enable ? PAT_SWITCH_ON : PAT_DISABLE_V;
            end
            ST_SWITCHED_ON:
            begin
                load_pat = 1'b1;
                pat      = to_enable ? PAT_ENABLE_OP : PAT_QUICKSTOP;
            end
            ST_ENABLED:
            begin
                load_pat = !to_enable;
                pat      = PAT_DISABLE_V;
            end
            ST_QUICKSTOP:
            begin
                load_pat = 1'b1;
                pat      = to_enable ? PAT_ENABLE_OP : PAT_DISABLE_V;
            end
            default:
            begin
                load_pat = 1'b0;
                pat      = PAT_DISABLE_V;
            end
        endcase
    end

    always_comb
    begin
        drive_state_next    = drive_state_reg;
        control_bits_next   = control_bits_reg;
        homing_pending_next = homing_pending_reg;
        new_target_next     = new_target_reg;
        current_mode_next   = current_mode_reg;
        out_data_next       = '0;

        case (cmd.op)
            OP_SYNC:
            begin
                control_bits_next = control_bits_reg & ~CW_HALT;
                if (!cmd.unknown)
                begin
                    drive_state_next = cmd.state;
                end
                current_mode_next = cmd.mode;
                out_data_next.unknown_status = cmd.unknown;
                if (drive_state_next != target)
                begin
                    if (load_pat)
                    begin
                        control_bits_next = {control_bits_next[15:8], pat};
                    end
                    out_data_next.transition_pending = 1'b1;
                end
                else if (homing_pending_reg)
                begin
                    out_data_next.mode_request = MODE_REQ_HOMING;
                    if (cmd.mode == MODE_HOMING)
                    begin
                        control_bits_next = control_bits_next | CW_MODE0;
                        if (cmd.homing_ok)
                        begin
                            homing_pending_next       = 1'b0;
                            out_data_next.homing_done = 1'b1;
                        end
                    end
                end
                else
                begin
                    out_data_next.motor_ready = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (drive_state_reg == ST_ENABLED)
                begin
                    case (current_mode_reg)
                        MODE_PP:
                        begin
                            if (new_target_reg)
                            begin
                                control_bits_next = control_bits_reg & ~CW_MODE_BITS;
                                new_target_next   = 1'b0;
                            end
                            else if (cmd.position_changed)
                            begin
                                new_target_next   = 1'b1;
                                control_bits_next = (control_bits_reg & ~CW_MODE_BITS)
                                                    | CW_MODE0;
                            end
                        end
                        MODE_PV:
                        begin
                            control_bits_next = control_bits_reg & ~CW_MODE_BITS;
                        end
                        MODE_IP:
                        begin
                            control_bits_next = (control_bits_reg & ~CW_MODE_BITS) | CW_MODE0;
                        end
                        MODE_VL:
                        begin
                            control_bits_next = control_bits_reg | CW_MODE_BITS;
                        end
                        default:
                        begin
                            control_bits_next = control_bits_reg;
                        end
                    endcase
                end
            end
            OP_HALT:
            begin
                control_bits_next = control_bits_reg | CW_HALT;
            end
            default:
            begin
                control_bits_next = control_bits_reg;
            end
        endcase

        out_data_next.ctrl_word    = control_bits_next;
        out_data_next.device_state = drive_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_enable_reg  <= 1'b0;
            homing_enable_reg  <= 1'b0;
            drive_state_reg    <= ST_NOT_READY;
            control_bits_reg   <= '0;
            homing_pending_reg <= 1'b0;
            new_target_reg     <= 1'b0;
            current_mode_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_TARGET_ENABLE)
            begin
                target_enable_reg <= cfg_data;
            end
            // homing enable also rearms the pending flag
            if (cfg_write && cfg_index == CFG_HOMING_ENABLE)
            begin
                homing_enable_reg  <= cfg_data;
                homing_pending_reg <= cfg_data;
            end
            else if (pop)
            begin
                homing_pending_reg <= homing_pending_next;
            end
            if (pop)
            begin
                drive_state_reg  <= drive_state_next;
                control_bits_reg <= control_bits_next;
                new_target_reg   <= new_target_next;
                current_mode_reg <= current_mode_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_ready_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.motor_ready && out_data_reg.transition_pending))
        else $error("motor ready while transition pending");

    a_done_needs_homing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.homing_done)
            |-> out_data_reg.mode_request == MODE_REQ_HOMING)
        else $error("homing done without homing mode request");

    a_non_sync_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.op != OP_SYNC) |=> (out_data_reg.unknown_status == 1'b0
            && out_data_reg.transition_pending == 1'b0 && out_data_reg.motor_ready == 1'b0
            && out_data_reg.homing_done == 1'b0 && out_data_reg.mode_request == MODE_REQ_NONE))
        else $error("status flags set on a non-sync word");

    a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_data_reg.device_state == drive_state_reg)
        else $error("reported state differs from stored state");

    homing_enable_used: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && out_data_next.homing_done) |-> homing_enable_reg || homing_pending_reg)
        else $error("homing finished while not armed");

endmodule
`default_nettype wire
